// ----- hdl/sbs_pkg.sv -----
// ----------------------------------------------------------------------------
// sbs_pkg
// Shared types and constants for the sorted breakpoint segmenter.
// ----------------------------------------------------------------------------
package sbs_pkg;

  localparam int MAX_BREAKPOINTS = 63;
  localparam int POS_W           = 31;
  localparam int CNT_W           = 6;
  localparam int STATUS_W        = 2;
  localparam int REG_IDX_W       = 1;

  localparam logic [REG_IDX_W-1:0] REG_REGION_START = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_REGION_END   = 1'b1;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_EMIT   = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_INSERTED  = 2'd0,
    STAT_DUPLICATE = 2'd1,
    STAT_FULL      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_WRITE,
    ST_STATUS,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             is_segment;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0] seg_index;
    logic [POS_W-1:0] seg_start;
    logic [POS_W-1:0] seg_end;
    logic             last;
  } result_t;

endpackage

// ----- hdl/sbs_engine.sv -----
// ----------------------------------------------------------------------------
// sbs_engine
// Breakpoint memory, shared comparator and sequencer for insert and emit.
// ----------------------------------------------------------------------------
module sbs_engine (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       req_type,
  input  logic [sbs_pkg::POS_W-1:0]  position,
  input  logic [sbs_pkg::POS_W-1:0]  region_start,
  input  logic [sbs_pkg::POS_W-1:0]  region_end,
  output logic                       res_valid,
  output sbs_pkg::result_t           res,
  input  logic                       res_take
);

  localparam logic [sbs_pkg::CNT_W-1:0] MAX_CNT = sbs_pkg::CNT_W'(sbs_pkg::MAX_BREAKPOINTS);
  localparam logic [sbs_pkg::CNT_W-1:0] ONE     = sbs_pkg::CNT_W'(1);
  localparam logic [sbs_pkg::CNT_W-1:0] TWO     = sbs_pkg::CNT_W'(2);

  sbs_pkg::state_t  state, state_next;
  sbs_pkg::status_t status_code;

  logic [sbs_pkg::CNT_W-1:0] count;
  logic [sbs_pkg::CNT_W-1:0] at;
  logic [sbs_pkg::CNT_W-1:0] idx;
  logic [sbs_pkg::POS_W-1:0] pos;
  logic [sbs_pkg::POS_W-1:0] prev;
  logic [sbs_pkg::POS_W-1:0] rd_data;

  logic [sbs_pkg::POS_W-1:0] mem [sbs_pkg::MAX_BREAKPOINTS];

  logic                      rd_en;
  logic [sbs_pkg::CNT_W-1:0] rd_addr;
  logic                      wr_en;
  logic [sbs_pkg::CNT_W-1:0] wr_addr;
  logic [sbs_pkg::POS_W-1:0] wr_data;

  logic accept;
  logic cmp_lt;
  logic cmp_eq;
  logic scan_end;
  logic full;
  logic emit_last;

  // shared comparator: table entry against the pending position
  assign cmp_lt = rd_data < pos;
  assign cmp_eq = rd_data == pos;

  assign accept    = in_valid && in_ready;
  assign scan_end  = (at + ONE) == count;
  assign full      = count == MAX_CNT;
  assign emit_last = idx == count;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sbs_pkg::ST_IDLE: begin
        if (accept) begin
          if (req_type == sbs_pkg::REQ_EMIT) begin
            state_next = sbs_pkg::ST_EMIT;
          end else if (count == '0) begin
            state_next = sbs_pkg::ST_WRITE;
          end else begin
            state_next = sbs_pkg::ST_SCAN;
          end
        end
      end
      sbs_pkg::ST_SCAN: begin
        if (cmp_eq || full) begin
          if (cmp_eq || !cmp_lt || scan_end) begin
            state_next = sbs_pkg::ST_STATUS;
          end
        end else if (!cmp_lt) begin
          state_next = sbs_pkg::ST_SHIFT;
        end else if (scan_end) begin
          state_next = sbs_pkg::ST_WRITE;
        end
      end
      sbs_pkg::ST_SHIFT: begin
        if ((idx - ONE) == at) begin
          state_next = sbs_pkg::ST_WRITE;
        end
      end
      sbs_pkg::ST_WRITE: state_next = sbs_pkg::ST_STATUS;
      sbs_pkg::ST_STATUS: begin
        if (res_take) begin
          state_next = sbs_pkg::ST_IDLE;
        end
      end
      sbs_pkg::ST_EMIT: begin
        if (res_take && emit_last) begin
          state_next = sbs_pkg::ST_IDLE;
        end
      end
      default: state_next = sbs_pkg::ST_IDLE;
    endcase
  end

  // outputs and memory port controls
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    res       = '0;
    res.last  = 1'b1;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = at;
    wr_data   = pos;
    unique case (state)
      sbs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        rd_en    = accept && (count != '0);
      end
      sbs_pkg::ST_SCAN: begin
        if (cmp_lt && !cmp_eq && !scan_end) begin
          rd_en   = 1'b1;
          rd_addr = at + ONE;
        end else if (!cmp_lt && !cmp_eq && !full) begin
          rd_en   = 1'b1;
          rd_addr = count - ONE;
        end
      end
      sbs_pkg::ST_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = idx;
        wr_data = rd_data;
        if ((idx - ONE) != at) begin
          rd_en   = 1'b1;
          rd_addr = idx - TWO;
        end
      end
      sbs_pkg::ST_WRITE: begin
        wr_en = 1'b1;
      end
      sbs_pkg::ST_STATUS: begin
        res_valid  = 1'b1;
        res.status = status_code;
      end
      sbs_pkg::ST_EMIT: begin
        res_valid      = 1'b1;
        res.is_segment = 1'b1;
        res.seg_index  = idx;
        res.seg_start  = (idx == '0) ? region_start : prev;
        res.seg_end    = emit_last ? region_end : rd_data;
        res.last       = emit_last;
        if (res_take && ((idx + ONE) < count)) begin
          rd_en   = 1'b1;
          rd_addr = idx + ONE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbs_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == sbs_pkg::ST_WRITE) begin
        count <= count + ONE;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      sbs_pkg::ST_IDLE: begin
        pos <= position;
        at  <= '0;
        idx <= '0;
      end
      sbs_pkg::ST_SCAN: begin
        if (cmp_eq) begin
          status_code <= sbs_pkg::STAT_DUPLICATE;
        end else if (cmp_lt) begin
          at <= at + ONE;
          if (scan_end) begin
            status_code <= sbs_pkg::STAT_FULL;
          end
        end else begin
          status_code <= sbs_pkg::STAT_FULL;
          idx         <= count;
        end
      end
      sbs_pkg::ST_SHIFT: begin
        idx <= idx - ONE;
      end
      sbs_pkg::ST_WRITE: begin
        status_code <= sbs_pkg::STAT_INSERTED;
      end
      sbs_pkg::ST_EMIT: begin
        if (res_take) begin
          prev <= rd_data;
          idx  <= idx + ONE;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- hdl/sorted_breakpoint_segmenter.sv -----
// ----------------------------------------------------------------------------
// sorted_breakpoint_segmenter
// Sorted unique breakpoint table with insert and segment emit requests.
// ----------------------------------------------------------------------------
// Takes one request at a time; in_ready stays low until its last result is
// loaded into the output register. During an insert the search reads one
// entry per cycle through the single read port of the breakpoint memory and
// one comparator, and entries above the insert point then move up one per
// cycle. A duplicate or full-table insert ends after the search. An emit
// produces n+1 segments for a table of n entries, one per cycle while
// out_ready is held high. The memory needs no clearing after reset.
module sorted_breakpoint_segmenter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [sbs_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [sbs_pkg::POS_W-1:0]          cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               req_type,
  input  logic [sbs_pkg::POS_W-1:0]          position,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               is_segment,
  output logic [sbs_pkg::STATUS_W-1:0]       status,
  output logic [sbs_pkg::CNT_W-1:0]          seg_index,
  output logic [sbs_pkg::POS_W-1:0]          seg_start,
  output logic [sbs_pkg::POS_W-1:0]          seg_end,
  output logic                               last
);

  logic [sbs_pkg::POS_W-1:0] region_start;
  logic [sbs_pkg::POS_W-1:0] region_end;
  logic                      res_valid;
  logic                      res_take;
  sbs_pkg::result_t          res;
  sbs_pkg::result_t          out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_start <= '0;
      region_end   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sbs_pkg::REG_REGION_START: region_start <= cfg_data;
        sbs_pkg::REG_REGION_END:   region_end   <= cfg_data;
        default: ;
      endcase
    end
  end

  sbs_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .position     (position),
    .region_start (region_start),
    .region_end   (region_end),
    .res_valid    (res_valid),
    .res          (res),
    .res_take     (res_take)
  );

  // output register loads a pending result whenever it is empty or being drained
  assign res_take = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= res;
    end
  end

  assign is_segment = out_res.is_segment;
  assign status     = out_res.status;
  assign seg_index  = out_res.seg_index;
  assign seg_start  = out_res.seg_start;
  assign seg_end    = out_res.seg_end;
  assign last       = out_res.last;

endmodule

// ----- hdl/sbs_checker.sv -----
// ----------------------------------------------------------------------------
// sbs_checker
// Port-level checks for the sorted breakpoint segmenter.
// ----------------------------------------------------------------------------
module sbs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          is_segment,
  input logic [sbs_pkg::STATUS_W-1:0]  status,
  input logic [sbs_pkg::CNT_W-1:0]     seg_index,
  input logic [sbs_pkg::POS_W-1:0]     seg_start,
  input logic [sbs_pkg::POS_W-1:0]     seg_end,
  input logic                          last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(seg_start) && $stable(seg_end)
      && $stable(status) && $stable(last))
    else $error("result changed while stalled");

  // one request in flight: busy right after a request is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // insert status is a single, final result
  a_status_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_segment |-> last && seg_index == '0 && status <= sbs_pkg::STAT_FULL)
    else $error("malformed status result");

  // segments carry status zero
  a_seg_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_segment |-> status == sbs_pkg::STAT_INSERTED)
    else $error("segment with nonzero status");

endmodule

bind sorted_breakpoint_segmenter sbs_checker u_sbs_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .is_segment (is_segment),
  .status     (status),
  .seg_index  (seg_index),
  .seg_start  (seg_start),
  .seg_end    (seg_end),
  .last       (last)
);
